// ===== rtl/core/intersection_light_sequencer_top_macros.svh =====
// Assertion macros used by the intersection light sequencer checker.
`ifndef INTERSECTION_LIGHT_SEQUENCER_TOP_MACROS_SVH
`define INTERSECTION_LIGHT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
// Shared types and codes of the intersection light sequencer.
`timescale 1ns / 1ps
`default_nettype none
package ils_pkg;

	localparam int TIME_WIDTH_DEF = 16;
	localparam int DUR_W = 16;
	localparam int LIM_W = DUR_W + 1;
	localparam int CFG_IDX_W = 3;

	typedef logic [1:0] light_t;
	typedef logic [1:0] mode_t;

	localparam light_t LT_OFF = 2'd0;
	localparam light_t LT_RED = 2'd1;
	localparam light_t LT_YELLOW = 2'd2;
	localparam light_t LT_GREEN = 2'd3;

	localparam mode_t MODE_NORMAL = 2'd0;
	localparam mode_t MODE_DISABLED = 2'd1;
	localparam mode_t MODE_BLINK = 2'd2;
	localparam mode_t MODE_DEBUG = 2'd3;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MODE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DBG_STATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DBG_BLINK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VEH_MASK = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PED_MASK = 3'd6;

	// Per-lane control from the mode logic for one request.
	typedef struct packed {
		logic   step;
		logic   load;
		logic   clear_timer;
		light_t load_light;
	} lane_ctrl_t;

	// Phase times seen by one lane.
	typedef struct packed {
		logic [LIM_W-1:0] red;
		logic [LIM_W-1:0] green;
		logic [LIM_W-1:0] yellow;
	} lane_limits_t;

endpackage
`default_nettype wire

// ===== rtl/core/intersection_light_sequencer_top.sv =====
// Top level of the intersection light sequencer.
// Accepts one request per clock while results are taken: a millisecond tick or
// a mode change. A request is held in the input register, then updates the
// eight light lanes and the mode in a single pass; the lane and mode registers
// themselves form the result, so each result is presented from them, behind the
// input register, and the sustained rate is one request per cycle while results
// are taken. The installed-light masks are applied on the outputs, so an absent
// light reads off. Configuration writes take effect at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module intersection_light_sequencer_top #(
	parameter int TIME_WIDTH = ils_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [1:0]                     new_mode,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     vehicle_north,
	output logic [1:0]                     vehicle_south,
	output logic [1:0]                     vehicle_east,
	output logic [1:0]                     vehicle_west,
	output logic [1:0]                     walk_north,
	output logic [1:0]                     walk_south,
	output logic [1:0]                     walk_east,
	output logic [1:0]                     walk_west,
	output logic                           blink_on,
	output logic [1:0]                     mode_now,
	input  logic                           cfg_write,
	input  logic [ils_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ils_pkg::DUR_W-1:0]      cfg_data
);
	import ils_pkg::*;

	logic [DUR_W-1:0] red_q;
	logic [DUR_W-1:0] green_q;
	logic [DUR_W-1:0] yellow_q;
	light_t           dbg_state_q;
	logic             dbg_blink_q;
	logic [3:0]       veh_mask_q;
	logic [3:0]       ped_mask_q;

	logic             valid_s1;
	logic             op_s1;
	mode_t            mode_s1;
	logic             valid_s2;

	mode_t            mode_q;
	logic             blink_q;

	logic             advance;
	logic             do_mode;
	logic             do_tick;
	light_t           force_light;

	lane_limits_t     veh_limits;
	lane_limits_t     ped_limits;
	lane_ctrl_t       veh_ctrl [4];
	lane_ctrl_t       ped_ctrl [4];
	light_t           veh_light [4];
	light_t           ped_light [4];
	light_t           veh_out [4];
	light_t           ped_out [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= 16'd5000;
			green_q <= 16'd4000;
			yellow_q <= 16'd1000;
			dbg_state_q <= LT_OFF;
			dbg_blink_q <= 1'b0;
			veh_mask_q <= 4'hF;
			ped_mask_q <= 4'hF;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RED: red_q <= cfg_data;
				CFG_GREEN: green_q <= cfg_data;
				CFG_YELLOW: yellow_q <= cfg_data;
				CFG_DBG_STATE: dbg_state_q <= cfg_data[1:0];
				CFG_DBG_BLINK: dbg_blink_q <= cfg_data[0];
				CFG_VEH_MASK: veh_mask_q <= cfg_data[3:0];
				CFG_PED_MASK: ped_mask_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// The state registers hold the result, so they may only move once the
	// previous result has been taken.
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign do_mode = advance && (op_s1 == OP_MODE);
	assign do_tick = advance && (op_s1 == OP_TICK) && (mode_q == MODE_NORMAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= operation;
			mode_s1 <= new_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DISABLED;
			blink_q <= 1'b0;
		end else if (do_mode) begin
			mode_q <= mode_s1;
			unique case (mode_s1)
				MODE_BLINK: blink_q <= 1'b1;
				MODE_DEBUG: blink_q <= dbg_blink_q;
				default: blink_q <= 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (mode_s1)
			MODE_BLINK: force_light = LT_YELLOW;
			MODE_DEBUG: force_light = dbg_state_q;
			default: force_light = LT_OFF;
		endcase
	end

	assign veh_limits.red = {1'b0, red_q};
	assign veh_limits.green = {1'b0, green_q};
	assign veh_limits.yellow = {1'b0, yellow_q};
	assign ped_limits.red = {1'b0, red_q};
	assign ped_limits.green = {1'b0, green_q} + {1'b0, yellow_q};
	assign ped_limits.yellow = {1'b0, yellow_q};

	// Entering normal mode starts north/south vehicles and east/west walks green.
	for (genvar i = 0; i < 4; i++) begin : g_lane
		always_comb begin
			veh_ctrl[i].step = do_tick && veh_mask_q[i];
			veh_ctrl[i].load = do_mode;
			veh_ctrl[i].clear_timer = (mode_s1 == MODE_NORMAL);
			ped_ctrl[i].step = do_tick && ped_mask_q[i];
			ped_ctrl[i].load = do_mode;
			ped_ctrl[i].clear_timer = (mode_s1 == MODE_NORMAL);
			if (mode_s1 == MODE_NORMAL) begin
				veh_ctrl[i].load_light = (i < 2) ? LT_GREEN : LT_RED;
				ped_ctrl[i].load_light = (i < 2) ? LT_RED : LT_GREEN;
			end else begin
				veh_ctrl[i].load_light = force_light;
				ped_ctrl[i].load_light = force_light;
			end
		end

		ils_lane #(.TIME_WIDTH(TIME_WIDTH)) u_veh (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (veh_ctrl[i]),
			.limits (veh_limits),
			.pair   (1'b0),
			.light  (veh_light[i])
		);

		ils_lane #(.TIME_WIDTH(TIME_WIDTH)) u_ped (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ped_ctrl[i]),
			.limits (ped_limits),
			.pair   (1'b1),
			.light  (ped_light[i])
		);

		assign veh_out[i] = veh_mask_q[i] ? veh_light[i] : LT_OFF;
		assign ped_out[i] = ped_mask_q[i] ? ped_light[i] : LT_OFF;
	end

	assign out_valid = valid_s2;
	assign vehicle_north = veh_out[0];
	assign vehicle_south = veh_out[1];
	assign vehicle_east = veh_out[2];
	assign vehicle_west = veh_out[3];
	assign walk_north = ped_out[0];
	assign walk_south = ped_out[1];
	assign walk_east = ped_out[2];
	assign walk_west = ped_out[3];
	assign blink_on = blink_q;
	assign mode_now = mode_q;

endmodule
`default_nettype wire

// ===== rtl/core/ils_lane.sv =====
// One light lane: phase register, millisecond timer and phase stepping.
`timescale 1ns / 1ps
`default_nettype none
module ils_lane #(
	parameter int TIME_WIDTH = ils_pkg::TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ils_pkg::lane_ctrl_t   ctrl,
	input  ils_pkg::lane_limits_t limits,
	input  logic                  pair,
	output ils_pkg::light_t       light
);
	import ils_pkg::*;

	localparam int CW = (TIME_WIDTH > LIM_W) ? TIME_WIDTH : LIM_W;

	light_t                light_q;
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [TIME_WIDTH-1:0] bumped;
	logic [LIM_W-1:0]      limit;
	light_t                nxt;
	logic                  active;
	logic                  reached;

	// A pedestrian pair has no yellow phase and goes from green straight to red.
	always_comb begin
		limit = limits.red;
		nxt = LT_GREEN;
		active = 1'b0;
		case (light_q)
			LT_RED: begin
				limit = limits.red;
				nxt = LT_GREEN;
				active = 1'b1;
			end
			LT_GREEN: begin
				limit = limits.green;
				nxt = pair ? LT_RED : LT_YELLOW;
				active = 1'b1;
			end
			LT_YELLOW: begin
				limit = limits.yellow;
				nxt = LT_RED;
				active = !pair;
			end
			default: begin
				limit = limits.red;
				nxt = LT_GREEN;
				active = 1'b0;
			end
		endcase
	end

	assign bumped = (elapsed_q == {TIME_WIDTH{1'b1}}) ? elapsed_q
		: elapsed_q + TIME_WIDTH'(1);
	assign reached = CW'(bumped) >= CW'(limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= LT_OFF;
			elapsed_q <= '0;
		end else if (ctrl.load) begin
			light_q <= ctrl.load_light;
			if (ctrl.clear_timer) begin
				elapsed_q <= '0;
			end
		end else if (ctrl.step && active) begin
			if (reached) begin
				light_q <= nxt;
				elapsed_q <= '0;
			end else begin
				elapsed_q <= bumped;
			end
		end
	end

	assign light = light_q;

endmodule
`default_nettype wire

// ===== rtl/core/ils_checker.sv =====
// Port-level checker for the intersection light sequencer, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "intersection_light_sequencer_top_macros.svh"
module ils_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] vehicle_north,
	input logic [1:0] vehicle_south,
	input logic [1:0] vehicle_east,
	input logic [1:0] vehicle_west,
	input logic [1:0] walk_north,
	input logic [1:0] walk_south,
	input logic [1:0] walk_east,
	input logic [1:0] walk_west,
	input logic       blink_on,
	input logic [1:0] mode_now
);
	import ils_pkg::*;

	logic        all_off;
	logic        walk_no_yellow;
	logic        all_yellow_or_off;
	logic        stalled;
	logic [18:0] result_word;
	logic        dark_ok;
	logic        blink_ok;
	logic        normal_ok;

	assign all_off = (vehicle_north == LT_OFF) && (vehicle_south == LT_OFF)
		&& (vehicle_east == LT_OFF) && (vehicle_west == LT_OFF)
		&& (walk_north == LT_OFF) && (walk_south == LT_OFF)
		&& (walk_east == LT_OFF) && (walk_west == LT_OFF);
	assign walk_no_yellow = (walk_north != LT_YELLOW) && (walk_south != LT_YELLOW)
		&& (walk_east != LT_YELLOW) && (walk_west != LT_YELLOW);
	assign all_yellow_or_off =
		((vehicle_north == LT_YELLOW) || (vehicle_north == LT_OFF))
		&& ((vehicle_south == LT_YELLOW) || (vehicle_south == LT_OFF))
		&& ((vehicle_east == LT_YELLOW) || (vehicle_east == LT_OFF))
		&& ((vehicle_west == LT_YELLOW) || (vehicle_west == LT_OFF))
		&& ((walk_north == LT_YELLOW) || (walk_north == LT_OFF))
		&& ((walk_south == LT_YELLOW) || (walk_south == LT_OFF))
		&& ((walk_east == LT_YELLOW) || (walk_east == LT_OFF))
		&& ((walk_west == LT_YELLOW) || (walk_west == LT_OFF));

	assign stalled = out_valid && !out_ready;
	assign result_word = {vehicle_north, vehicle_south, vehicle_east, vehicle_west,
		walk_north, walk_south, walk_east, walk_west, blink_on, mode_now};
	assign dark_ok = all_off && !blink_on;
	assign blink_ok = all_yellow_or_off && blink_on;
	assign normal_ok = walk_no_yellow && !blink_on;

	`ILS_ASSERT_NEXT(a_result_holds, stalled, out_valid && $stable(result_word), "result moved")
	`ILS_ASSERT_NOW(a_stall_backpressure, !in_ready, stalled, "input held without a stall")
	`ILS_ASSERT_NOW(a_disabled_dark, mode_now == MODE_DISABLED, dark_ok, "lit while disabled")
	`ILS_ASSERT_NOW(a_blink_yellow, mode_now == MODE_BLINK, blink_ok, "bad blink pattern")
	`ILS_ASSERT_NOW(a_normal_walk, mode_now == MODE_NORMAL, normal_ok, "bad normal pattern")

endmodule

bind intersection_light_sequencer_top ils_checker u_ils_checker (.*);
`default_nettype wire
